/* rtl/core/lslb_pkg.sv */
// shared types, constants and helpers of the link status led blinker
`default_nettype none

package lslb_pkg;

    // width of the elapsed-time counters
    localparam int COUNTER_BITS = 16;
    // width of the configuration registers and the write data
    localparam int CFG_BITS     = 16;
    localparam int TOGGLE_BITS  = 4;
    localparam int CFG_IDX_BITS = 3;
    // compares run at the wider of counter and register width
    localparam int CMP_BITS     = (COUNTER_BITS > CFG_BITS) ? COUNTER_BITS : CFG_BITS;

    typedef logic [COUNTER_BITS-1:0] t_cnt;
    typedef logic [CMP_BITS-1:0]     t_cmp;
    typedef logic [CFG_IDX_BITS-1:0] t_cfg_idx;

    localparam t_cnt CNT_MAX = '1;

    // colour codes, also the led slot of each colour
    localparam logic [1:0] COLOUR_GREEN = 2'd0;
    localparam logic [1:0] COLOUR_BLUE  = 2'd1;
    localparam logic [1:0] COLOUR_RED   = 2'd2;

    // register indexes
    localparam t_cfg_idx REG_FRESH_WINDOW  = 3'd0;
    localparam t_cfg_idx REG_LOST_TIMEOUT  = 3'd1;
    localparam t_cfg_idx REG_BURST_PERIOD  = 3'd2;
    localparam t_cfg_idx REG_BURST_PAUSE   = 3'd3;
    localparam t_cfg_idx REG_BURST_TOGGLES = 3'd4;
    localparam t_cfg_idx REG_RAPID_PERIOD  = 3'd5;

    // register reset values
    localparam logic [CFG_BITS-1:0]    RST_FRESH_WINDOW  = 16'd500;
    localparam logic [CFG_BITS-1:0]    RST_LOST_TIMEOUT  = 16'd5000;
    localparam logic [CFG_BITS-1:0]    RST_BURST_PERIOD  = 16'd100;
    localparam logic [CFG_BITS-1:0]    RST_BURST_PAUSE   = 16'd1000;
    localparam logic [TOGGLE_BITS-1:0] RST_BURST_TOGGLES = 4'd6;
    localparam logic [CFG_BITS-1:0]    RST_RAPID_PERIOD  = 16'd50;

    typedef struct packed {
        logic [CFG_BITS-1:0]    fresh_window;
        logic [CFG_BITS-1:0]    lost_timeout;
        logic [CFG_BITS-1:0]    burst_period;
        logic [CFG_BITS-1:0]    burst_pause;
        logic [TOGGLE_BITS-1:0] burst_toggles;
        logic [CFG_BITS-1:0]    rapid_period;
    } t_cfg;

    typedef struct packed {
        logic packet_received;
        logic dropped_update;
        logic dropped_value;
        logic link_enabled;
    } t_in;

    typedef struct packed {
        logic       green_led;
        logic       red_led;
        logic       blue_led;
        logic [1:0] active_colour;
    } t_out;

    // drive the led slot of the given colour
    function automatic logic [2:0] set_led(input logic [2:0] leds, input logic [1:0] col,
                                           input logic lvl);
        logic [2:0] res;
        res = leds;
        case (col)
            COLOUR_GREEN: res[COLOUR_GREEN] = lvl;
            COLOUR_BLUE:  res[COLOUR_BLUE]  = lvl;
            COLOUR_RED:   res[COLOUR_RED]   = lvl;
            default:      res = leds;
        endcase
        return res;
    endfunction

    // saturating increment of an elapsed counter
    function automatic t_cnt sat_inc(input t_cnt c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/lslb_cfg_regs.sv */
// configuration register bank of the link status led blinker
`default_nettype none

module lslb_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire lslb_pkg::t_cfg_idx           i_cfg_idx,
    input  wire logic [lslb_pkg::CFG_BITS-1:0] i_cfg_data,
    output lslb_pkg::t_cfg                    o_cfg
);

    lslb_pkg::t_cfg r_cfg;

    // register writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fresh_window  <= lslb_pkg::RST_FRESH_WINDOW;
            r_cfg.lost_timeout  <= lslb_pkg::RST_LOST_TIMEOUT;
            r_cfg.burst_period  <= lslb_pkg::RST_BURST_PERIOD;
            r_cfg.burst_pause   <= lslb_pkg::RST_BURST_PAUSE;
            r_cfg.burst_toggles <= lslb_pkg::RST_BURST_TOGGLES;
            r_cfg.rapid_period  <= lslb_pkg::RST_RAPID_PERIOD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lslb_pkg::REG_FRESH_WINDOW:  r_cfg.fresh_window <= i_cfg_data;
                lslb_pkg::REG_LOST_TIMEOUT:  r_cfg.lost_timeout <= i_cfg_data;
                lslb_pkg::REG_BURST_PERIOD:  r_cfg.burst_period <= i_cfg_data;
                lslb_pkg::REG_BURST_PAUSE:   r_cfg.burst_pause  <= i_cfg_data;
                lslb_pkg::REG_BURST_TOGGLES: begin
                    r_cfg.burst_toggles <= i_cfg_data[lslb_pkg::TOGGLE_BITS-1:0];
                end
                lslb_pkg::REG_RAPID_PERIOD:  r_cfg.rapid_period <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/core/lslb_core.sv */
// blink state and its per-tick update
`default_nettype none

module lslb_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire lslb_pkg::t_in  i_tick,
    input  wire lslb_pkg::t_cfg i_cfg,
    output lslb_pkg::t_out      o_result
);

    lslb_pkg::t_cnt r_since_rx, n_since_rx;
    lslb_pkg::t_cnt r_since_burst, n_since_burst;
    lslb_pkg::t_cnt r_since_rapid, n_since_rapid;
    logic [lslb_pkg::TOGGLE_BITS-1:0] r_toggle_cnt, n_toggle_cnt;
    logic       r_burst_lvl, n_burst_lvl;
    logic       r_rapid_lvl, n_rapid_lvl;
    logic       r_dropped, n_dropped;
    logic [1:0] r_colour, n_colour;
    logic [2:0] r_leds, n_leds;

    lslb_pkg::t_cnt adv_since_burst;
    lslb_pkg::t_cnt adv_since_rapid;
    logic [1:0] link_colour;
    logic       is_fresh;
    logic       is_lost;
    logic       do_burst;
    logic       do_rapid;

    // counters advance, then packet and dropped report apply
    always_comb begin
        n_since_rx      = lslb_pkg::sat_inc(r_since_rx);
        adv_since_burst = lslb_pkg::sat_inc(r_since_burst);
        adv_since_rapid = lslb_pkg::sat_inc(r_since_rapid);
        if (i_tick.packet_received) begin
            n_since_rx = '0;
        end
        n_dropped = i_tick.dropped_update ? i_tick.dropped_value : r_dropped;
    end

    // link band
    assign link_colour = n_dropped ? lslb_pkg::COLOUR_BLUE : lslb_pkg::COLOUR_GREEN;
    assign is_fresh = lslb_pkg::t_cmp'(n_since_rx) < lslb_pkg::t_cmp'(i_cfg.fresh_window);
    assign is_lost  = lslb_pkg::t_cmp'(n_since_rx) > lslb_pkg::t_cmp'(i_cfg.lost_timeout);

    // colour choice, forced-off leds, then burst or rapid pattern
    always_comb begin
        n_colour      = r_colour;
        n_leds        = r_leds;
        n_toggle_cnt  = r_toggle_cnt;
        n_burst_lvl   = r_burst_lvl;
        n_rapid_lvl   = r_rapid_lvl;
        n_since_burst = adv_since_burst;
        n_since_rapid = adv_since_rapid;
        do_burst      = 1'b0;
        do_rapid      = 1'b0;
        if (i_tick.link_enabled) begin
            if (is_fresh) begin
                n_colour = link_colour;
                n_leds[lslb_pkg::COLOUR_RED] = 1'b0;
                if (n_dropped) begin
                    n_leds[lslb_pkg::COLOUR_GREEN] = 1'b0;
                end else begin
                    n_leds[lslb_pkg::COLOUR_BLUE] = 1'b0;
                end
                do_burst = 1'b1;
            end else if (is_lost) begin
                n_leds[lslb_pkg::COLOUR_GREEN] = 1'b0;
                n_leds[lslb_pkg::COLOUR_BLUE]  = 1'b0;
                n_colour = lslb_pkg::COLOUR_RED;
                do_burst = 1'b1;
            end else begin
                n_colour = link_colour;
                do_rapid = 1'b1;
            end
        end else begin
            n_colour = lslb_pkg::COLOUR_RED;
            do_burst = 1'b1;
        end

        // burst: toggles up to the count, then a pause
        if (do_burst) begin
            if (r_toggle_cnt < i_cfg.burst_toggles) begin
                if (lslb_pkg::t_cmp'(adv_since_burst) > lslb_pkg::t_cmp'(i_cfg.burst_period)) begin
                    n_burst_lvl   = ~r_burst_lvl;
                    n_toggle_cnt  = r_toggle_cnt + 1'b1;
                    n_leds        = lslb_pkg::set_led(n_leds, n_colour, n_burst_lvl);
                    n_since_burst = '0;
                end
            end else if (lslb_pkg::t_cmp'(adv_since_burst) >
                         lslb_pkg::t_cmp'(i_cfg.burst_pause)) begin
                n_toggle_cnt = '0;
                n_leds       = lslb_pkg::set_led(n_leds, n_colour, 1'b0);
            end
        end

        // rapid toggling in the band between fresh and lost
        if (do_rapid) begin
            if (lslb_pkg::t_cmp'(adv_since_rapid) > lslb_pkg::t_cmp'(i_cfg.rapid_period)) begin
                n_rapid_lvl   = ~r_rapid_lvl;
                n_leds        = lslb_pkg::set_led(n_leds, n_colour, n_rapid_lvl);
                n_since_rapid = '0;
            end
        end
    end

    // state update on each tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_since_rx    <= '0;
            r_since_burst <= '0;
            r_since_rapid <= '0;
            r_toggle_cnt  <= '0;
            r_burst_lvl   <= 1'b0;
            r_rapid_lvl   <= 1'b0;
            r_dropped     <= 1'b0;
            r_colour      <= lslb_pkg::COLOUR_RED;
            r_leds        <= '0;
        end else if (i_step) begin
            r_since_rx    <= n_since_rx;
            r_since_burst <= n_since_burst;
            r_since_rapid <= n_since_rapid;
            r_toggle_cnt  <= n_toggle_cnt;
            r_burst_lvl   <= n_burst_lvl;
            r_rapid_lvl   <= n_rapid_lvl;
            r_dropped     <= n_dropped;
            r_colour      <= n_colour;
            r_leds        <= n_leds;
        end
    end

    // result of this tick, taken after the update
    always_comb begin
        o_result.green_led     = n_leds[lslb_pkg::COLOUR_GREEN];
        o_result.red_led       = n_leds[lslb_pkg::COLOUR_RED];
        o_result.blue_led      = n_leds[lslb_pkg::COLOUR_BLUE];
        o_result.active_colour = n_colour;
    end

endmodule

`default_nettype wire

/* rtl/core/link_status_led_blinker_top.sv */
// Link status LED blinker. One request is one millisecond tick and gives one result with the
// green, red and blue LED levels and the active colour. A request is taken into an input
// register; from there the blink state is updated by single-level compare and counter logic
// and the result is written to the output register, so a new request is taken every cycle
// while results are taken. The output register alone stalls the flow: if it holds an untaken
// result, one more request waits in the input register. Configuration writes are taken at
// any time and act from the next tick on; they are meant for periods when no tick is in
// flight.
`default_nettype none

module link_status_led_blinker_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire lslb_pkg::t_in                 i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output lslb_pkg::t_out                     o_out_data,
    input  wire logic                          i_cfg_we,
    input  wire lslb_pkg::t_cfg_idx            i_cfg_idx,
    input  wire logic [lslb_pkg::CFG_BITS-1:0] i_cfg_data
);

    lslb_pkg::t_cfg cfg;
    lslb_pkg::t_out result;
    lslb_pkg::t_in  r_in_data;
    lslb_pkg::t_out r_out_data;
    logic           r_in_valid;
    logic           r_out_valid;
    logic           advance;
    logic           in_accept;

    // handshake control
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = i_rst_n && (!r_in_valid || advance);
    assign in_accept  = i_in_valid && o_in_ready;

    lslb_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lslb_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_tick   (r_in_data),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_data <= i_in_data;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

/* rtl/core/lslb_checker.sv */
// port-level checks of the link status led blinker and their bind
`default_nettype none

module lslb_assertions (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_ready,
    input wire logic           o_out_valid,
    input wire logic           i_out_ready,
    input wire lslb_pkg::t_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    // colour code is never the unused value
    a_colour_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.active_colour != 2'd3)
        else $error("active colour out of range");

    // requests are refused only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("request refused without output stall");

    // a fresh result follows an accepted request
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && o_in_ready, 2))
        else $error("result without matching request");

endmodule

bind link_status_led_blinker_top lslb_assertions u_lslb_assertions (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
